// File: src/pibb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package pibb_pkg;

    // Widths fixed by the register and field formats.
    localparam int CFG_W   = 13;
    localparam int PIX_W   = 8;
    localparam int OUT_W   = 13;
    localparam int IDX_W   = 3;

    // Largest frame dimension supported by default.
    localparam int MAX_DIM_DEFAULT = 4096;

    // Register values after reset.
    localparam logic [CFG_W-1:0] RST_FRAME_WIDTH  = CFG_W'(612);
    localparam logic [CFG_W-1:0] RST_FRAME_HEIGHT = CFG_W'(792);
    localparam logic             RST_MASK_ENABLE  = 1'b0;
    localparam logic [CFG_W-1:0] RST_MASK_TOP     = CFG_W'(70);
    localparam logic [CFG_W-1:0] RST_MASK_BOTTOM  = CFG_W'(20);

    // Register indexes on the configuration port.
    localparam logic [IDX_W-1:0] CFG_IDX_FRAME_WIDTH  = IDX_W'(0);
    localparam logic [IDX_W-1:0] CFG_IDX_FRAME_HEIGHT = IDX_W'(1);
    localparam logic [IDX_W-1:0] CFG_IDX_MASK_ENABLE  = IDX_W'(2);
    localparam logic [IDX_W-1:0] CFG_IDX_MASK_TOP     = IDX_W'(3);
    localparam logic [IDX_W-1:0] CFG_IDX_MASK_BOTTOM  = IDX_W'(4);

    // Status handed from the tracker to the result stage.
    typedef struct packed {
        logic frame_end;
        logic seen;
    } frame_ctl_t;

endpackage

`default_nettype wire

// File: src/pibb_track.sv
`timescale 1ns / 1ps
`default_nettype none

module pibb_track #(
    parameter int MAX_DIM = pibb_pkg::MAX_DIM_DEFAULT,
    localparam int CW = $clog2(MAX_DIM),
    localparam int EW = ((CW > pibb_pkg::CFG_W) ? CW : pibb_pkg::CFG_W) + 1
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          advance,
    input  wire logic [pibb_pkg::PIX_W-1:0]    pixel,
    input  wire logic [EW-1:0]                 width_eff,
    input  wire logic [EW-1:0]                 height_eff,
    input  wire logic                          mask_enable,
    input  wire logic [pibb_pkg::CFG_W-1:0]    mask_top_rows,
    input  wire logic [pibb_pkg::CFG_W-1:0]    mask_bottom_rows,
    output pibb_pkg::frame_ctl_t               ctl,
    output logic [CW-1:0]                      min_col,
    output logic [CW-1:0]                      max_col,
    output logic [CW-1:0]                      first_row,
    output logic [CW-1:0]                      last_row
);

    logic [CW-1:0] col_reg, col_next;
    logic [CW-1:0] row_reg, row_next;
    logic [CW-1:0] min_col_reg, max_col_reg, first_row_reg, last_row_reg;
    logic          seen_reg;
    logic          blank, hit, row_end;

    always_comb begin
        blank = mask_enable &&
                ((EW'(row_reg) < EW'(mask_top_rows)) ||
                 (EW'(row_reg) + EW'(mask_bottom_rows) >= height_eff));
        hit = (pixel != '0) && !blank;

        min_col   = min_col_reg;
        max_col   = max_col_reg;
        first_row = first_row_reg;
        last_row  = last_row_reg;
        if (hit) begin
            if (!seen_reg || col_reg < min_col_reg) begin
                min_col = col_reg;
            end
            if (!seen_reg || col_reg > max_col_reg) begin
                max_col = col_reg;
            end
            if (!seen_reg || row_reg < first_row_reg) begin
                first_row = row_reg;
            end
            if (!seen_reg || row_reg > last_row_reg) begin
                last_row = row_reg;
            end
        end

        row_end       = (EW'(col_reg) + EW'(1) >= width_eff);
        ctl.frame_end = row_end && (EW'(row_reg) + EW'(1) >= height_eff);
        ctl.seen      = seen_reg || hit;

        if (row_end) begin
            col_next = '0;
            row_next = row_reg + CW'(1);
        end else begin
            col_next = col_reg + CW'(1);
            row_next = row_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg       <= '0;
            row_reg       <= '0;
            min_col_reg   <= '1;
            max_col_reg   <= '0;
            first_row_reg <= '1;
            last_row_reg  <= '0;
            seen_reg      <= 1'b0;
        end else if (advance) begin
            if (ctl.frame_end) begin
                col_reg       <= '0;
                row_reg       <= '0;
                min_col_reg   <= '1;
                max_col_reg   <= '0;
                first_row_reg <= '1;
                last_row_reg  <= '0;
                seen_reg      <= 1'b0;
            end else begin
                col_reg       <= col_next;
                row_reg       <= row_next;
                min_col_reg   <= min_col;
                max_col_reg   <= max_col;
                first_row_reg <= first_row;
                last_row_reg  <= last_row;
                seen_reg      <= ctl.seen;
            end
        end
    end

endmodule

`default_nettype wire

// File: src/pibb_result.sv
`timescale 1ns / 1ps
`default_nettype none

module pibb_result #(
    parameter int MAX_DIM = pibb_pkg::MAX_DIM_DEFAULT,
    localparam int CW = $clog2(MAX_DIM),
    localparam int EW = ((CW > pibb_pkg::CFG_W) ? CW : pibb_pkg::CFG_W) + 1
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       load,
    input  wire logic [EW-1:0]              width_eff,
    input  wire logic [EW-1:0]              height_eff,
    input  pibb_pkg::frame_ctl_t            ctl,
    input  wire logic [CW-1:0]              min_col,
    input  wire logic [CW-1:0]              max_col,
    input  wire logic [CW-1:0]              first_row,
    input  wire logic [CW-1:0]              last_row,
    input  wire logic                       out_ready,
    output logic                            out_valid,
    output logic [pibb_pkg::OUT_W-1:0]      box_left,
    output logic [pibb_pkg::OUT_W-1:0]      box_bottom,
    output logic [pibb_pkg::OUT_W-1:0]      box_right,
    output logic [pibb_pkg::OUT_W-1:0]      box_top
);

    logic                        valid_reg;
    logic [pibb_pkg::OUT_W-1:0]  left_reg, bottom_reg, right_reg, top_reg;
    logic [EW-1:0]               left_next, bottom_next, right_next, top_next;

    always_comb begin
        if (ctl.seen) begin
            left_next  = EW'(min_col);
            right_next = EW'(max_col) + EW'(1);
            // Edges saturate at zero if the height shrank mid-frame.
            if (EW'(last_row) + EW'(1) <= height_eff) begin
                bottom_next = height_eff - EW'(1) - EW'(last_row);
            end else begin
                bottom_next = '0;
            end
            if (EW'(first_row) <= height_eff) begin
                top_next = height_eff - EW'(first_row);
            end else begin
                top_next = '0;
            end
        end else begin
            left_next   = '0;
            bottom_next = '0;
            right_next  = width_eff;
            top_next    = height_eff;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (load) begin
            valid_reg <= 1'b1;
        end else if (out_ready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            left_reg   <= left_next[pibb_pkg::OUT_W-1:0];
            bottom_reg <= bottom_next[pibb_pkg::OUT_W-1:0];
            right_reg  <= right_next[pibb_pkg::OUT_W-1:0];
            top_reg    <= top_next[pibb_pkg::OUT_W-1:0];
        end
    end

    assign out_valid  = valid_reg;
    assign box_left   = left_reg;
    assign box_bottom = bottom_reg;
    assign box_right  = right_reg;
    assign box_top    = top_reg;

endmodule

`default_nettype wire

// File: src/page_ink_bounding_box_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   | Ports                                    | Moves
// ----------+------------------------------------------+-------------------------------
// input     | s_valid, s_ready, s_pixel_value          | one pixel, row order, top first
// result    | m_valid, m_ready, m_box_*                | one crop rectangle per frame
// config    | cfg_we, cfg_index, cfg_wdata             | register write, no handshake
//
// One pixel can be accepted in every cycle. A pixel waits in the input register and
// then updates the counters and extents; a frame's last pixel, as it leaves the input
// register, loads the result register and raises m_valid. Reset (aresetn, synchronous,
// active low) restores the register defaults and starts a new frame at column 0, row 0.
// Only a frame's last pixel waits on a full result register, and s_ready is low
// while it waits; all other pixels keep flowing while a rectangle waits for its transfer.
module page_ink_bounding_box_core #(
    parameter int MAX_DIM = pibb_pkg::MAX_DIM_DEFAULT
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,

    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic [pibb_pkg::PIX_W-1:0]    s_pixel_value,

    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic [pibb_pkg::OUT_W-1:0]         m_box_left,
    output logic [pibb_pkg::OUT_W-1:0]         m_box_bottom,
    output logic [pibb_pkg::OUT_W-1:0]         m_box_right,
    output logic [pibb_pkg::OUT_W-1:0]         m_box_top,

    input  wire logic                          cfg_we,
    input  wire logic [pibb_pkg::IDX_W-1:0]    cfg_index,
    input  wire logic [pibb_pkg::CFG_W-1:0]    cfg_wdata
);

    localparam int CW = $clog2(MAX_DIM);
    localparam int EW = ((CW > pibb_pkg::CFG_W) ? CW : pibb_pkg::CFG_W) + 1;

    // Configuration registers.
    logic [pibb_pkg::CFG_W-1:0] frame_width_reg, frame_height_reg;
    logic [pibb_pkg::CFG_W-1:0] mask_top_reg, mask_bottom_reg;
    logic                       mask_enable_reg;

    // Input register.
    logic                       p_valid_reg;
    logic [pibb_pkg::PIX_W-1:0] p_pixel_reg;

    logic [EW-1:0]              width_eff, height_eff;
    logic                       advance;
    pibb_pkg::frame_ctl_t       ctl;
    logic [CW-1:0]              min_col, max_col, first_row, last_row;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_width_reg  <= pibb_pkg::RST_FRAME_WIDTH;
            frame_height_reg <= pibb_pkg::RST_FRAME_HEIGHT;
            mask_enable_reg  <= pibb_pkg::RST_MASK_ENABLE;
            mask_top_reg     <= pibb_pkg::RST_MASK_TOP;
            mask_bottom_reg  <= pibb_pkg::RST_MASK_BOTTOM;
        end else if (cfg_we) begin
            case (cfg_index)
                pibb_pkg::CFG_IDX_FRAME_WIDTH:  frame_width_reg  <= cfg_wdata;
                pibb_pkg::CFG_IDX_FRAME_HEIGHT: frame_height_reg <= cfg_wdata;
                pibb_pkg::CFG_IDX_MASK_ENABLE:  mask_enable_reg  <= cfg_wdata[0];
                pibb_pkg::CFG_IDX_MASK_TOP:     mask_top_reg     <= cfg_wdata;
                pibb_pkg::CFG_IDX_MASK_BOTTOM:  mask_bottom_reg  <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // The frame size in use is the register value limited to 1..MAX_DIM.
    always_comb begin
        if (frame_width_reg == '0) begin
            width_eff = EW'(1);
        end else if (EW'(frame_width_reg) > EW'(MAX_DIM)) begin
            width_eff = EW'(MAX_DIM);
        end else begin
            width_eff = EW'(frame_width_reg);
        end
        if (frame_height_reg == '0) begin
            height_eff = EW'(1);
        end else if (EW'(frame_height_reg) > EW'(MAX_DIM)) begin
            height_eff = EW'(MAX_DIM);
        end else begin
            height_eff = EW'(frame_height_reg);
        end
    end

    // A held pixel moves on unless it closes a frame while the result register
    // still holds a rectangle that is not being taken in this cycle.
    assign advance = p_valid_reg && (!ctl.frame_end || !m_valid || m_ready);
    assign s_ready = !p_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p_valid_reg <= 1'b0;
        end else if (s_ready) begin
            p_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            p_pixel_reg <= s_pixel_value;
        end
    end

    pibb_track #(
        .MAX_DIM(MAX_DIM)
    ) u_track (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .advance          (advance),
        .pixel            (p_pixel_reg),
        .width_eff        (width_eff),
        .height_eff       (height_eff),
        .mask_enable      (mask_enable_reg),
        .mask_top_rows    (mask_top_reg),
        .mask_bottom_rows (mask_bottom_reg),
        .ctl              (ctl),
        .min_col          (min_col),
        .max_col          (max_col),
        .first_row        (first_row),
        .last_row         (last_row)
    );

    pibb_result #(
        .MAX_DIM(MAX_DIM)
    ) u_result (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .load       (advance && ctl.frame_end),
        .width_eff  (width_eff),
        .height_eff (height_eff),
        .ctl        (ctl),
        .min_col    (min_col),
        .max_col    (max_col),
        .first_row  (first_row),
        .last_row   (last_row),
        .out_ready  (m_ready),
        .out_valid  (m_valid),
        .box_left   (m_box_left),
        .box_bottom (m_box_bottom),
        .box_right  (m_box_right),
        .box_top    (m_box_top)
    );

endmodule

`default_nettype wire

// File: tb/tb_page_ink_bounding_box_core.sv
`timescale 1ns / 1ps

module tb_page_ink_bounding_box_core;

    import pibb_pkg::*;

    // The rectangle of a frame is registered in the result stage after its last pixel
    // has passed the input register. The settling wait beyond that covers pixels that
    // are still in flight when the last expected rectangle has already arrived.
    localparam int RESULT_LATENCY = 2;
    localparam int SETTLE_CYCLES  = RESULT_LATENCY + 4;
    localparam int HOLD_CYCLES    = 300;
    localparam int RANDOM_PIXELS  = 1500;
    localparam int TIMEOUT_NS     = 10_000_000;
    localparam int MAX_DIM        = MAX_DIM_DEFAULT;
    localparam int ALL_ONES_CFG   = (1 << CFG_W) - 1;
    localparam int FIRST_SPARE_INDEX = int'(CFG_IDX_MASK_BOTTOM) + 1;

    typedef struct packed {
        logic [OUT_W-1:0] left;
        logic [OUT_W-1:0] bottom;
        logic [OUT_W-1:0] right;
        logic [OUT_W-1:0] top;
    } crop_box_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;

    logic             s_valid = 1'b0;
    logic             s_ready;
    logic [PIX_W-1:0] s_pixel_value = '0;

    logic             m_valid;
    logic             m_ready = 1'b0;
    logic [OUT_W-1:0] m_box_left;
    logic [OUT_W-1:0] m_box_bottom;
    logic [OUT_W-1:0] m_box_right;
    logic [OUT_W-1:0] m_box_top;

    logic             cfg_we = 1'b0;
    logic [IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0] cfg_wdata = '0;

    page_ink_bounding_box_core uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_pixel_value (s_pixel_value),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_box_left    (m_box_left),
        .m_box_bottom  (m_box_bottom),
        .m_box_right   (m_box_right),
        .m_box_top     (m_box_top),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata)
    );

    always #5 aclk = ~aclk;

    // Shadow copy of the registers. They start at their reset values, since
    // reset is applied only once at the start of the run.
    int unsigned reg_width       = RST_FRAME_WIDTH;
    int unsigned reg_height      = RST_FRAME_HEIGHT;
    bit          reg_mask_en     = RST_MASK_ENABLE;
    int unsigned reg_mask_top    = RST_MASK_TOP;
    int unsigned reg_mask_bottom = RST_MASK_BOTTOM;

    // Raster position and ink extent of the frame that is being scanned.
    int unsigned scan_col;
    int unsigned scan_row;
    int unsigned ink_col_min;
    int unsigned ink_col_max;
    int unsigned ink_row_min;
    int unsigned ink_row_max;
    bit          ink_found;

    // Crop rectangles that the block still owes, oldest first.
    crop_box_t   pending_boxes[$];
    crop_box_t   oldest_box;
    int          mismatches;

    // Traffic shaping. The sender works in bursts, and the receiver follows a
    // ready/stall pattern of its own; each can be switched off for a stretch.
    bit          tx_gaps_on;
    bit          rx_stalls_on;
    int unsigned burst_left;
    bit          hold_request;
    int unsigned hold_left;
    bit          rx_ready_phase;
    int unsigned rx_run;

    // A register value of 0 acts as 1, and anything above the largest
    // supported dimension acts as that dimension.
    function automatic int unsigned limit_dimension(int unsigned value);
        if (value < 1) return 1;
        if (value > MAX_DIM) return MAX_DIM;
        return value;
    endfunction

    task automatic clear_extent();
        scan_col    = 0;
        scan_row    = 0;
        ink_col_min = '1;
        ink_col_max = 0;
        ink_row_min = '1;
        ink_row_max = 0;
        ink_found   = 1'b0;
    endtask

    task automatic apply_register(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] data);
        case (idx)
            CFG_IDX_FRAME_WIDTH:  reg_width       = data;
            CFG_IDX_FRAME_HEIGHT: reg_height      = data;
            CFG_IDX_MASK_ENABLE:  reg_mask_en     = data[0];
            CFG_IDX_MASK_TOP:     reg_mask_top    = data;
            CFG_IDX_MASK_BOTTOM:  reg_mask_bottom = data;
            default: ;
        endcase
    endtask

    // Advances the raster position by one pixel and, on the frame's last
    // pixel, queues the crop rectangle in bottom-up page coordinates.
    task automatic track_pixel(logic [PIX_W-1:0] pix);
        int unsigned w;
        int unsigned h;
        int unsigned col;
        int unsigned row;
        bit          blank;
        bit          row_done;
        bit          frame_done;
        crop_box_t   box;
        w     = limit_dimension(reg_width);
        h     = limit_dimension(reg_height);
        col   = scan_col;
        row   = scan_row;
        // Rows in either masked band count as blank, so the bands may overlap.
        blank = reg_mask_en && (row < reg_mask_top || row + reg_mask_bottom >= h);
        if (pix != 0 && !blank) begin
            if (!ink_found || col < ink_col_min) ink_col_min = col;
            if (!ink_found || col > ink_col_max) ink_col_max = col;
            if (!ink_found || row < ink_row_min) ink_row_min = row;
            if (!ink_found || row > ink_row_max) ink_row_max = row;
            ink_found = 1'b1;
        end
        // Counters compare with >= so that a size shrunk in mid-frame ends the
        // row or the frame at the very next pixel.
        row_done   = (col + 1 >= w);
        frame_done = row_done && (row + 1 >= h);
        if (!frame_done) begin
            if (row_done) begin
                scan_col = 0;
                scan_row = row + 1;
            end else begin
                scan_col = col + 1;
            end
        end else begin
            if (ink_found) begin
                // Ink above a height that shrank in mid-frame saturates at 0.
                box.left   = OUT_W'(ink_col_min);
                box.bottom = OUT_W'((ink_row_max + 1 <= h) ? h - 1 - ink_row_max : 0);
                box.right  = OUT_W'(ink_col_max + 1);
                box.top    = OUT_W'((ink_row_min <= h) ? h - ink_row_min : 0);
            end else begin
                // No ink at all gives the full page.
                box.left   = '0;
                box.bottom = '0;
                box.right  = OUT_W'(w);
                box.top    = OUT_W'(h);
            end
            pending_boxes.push_back(box);
            clear_extent();
        end
    endtask

    // The prediction follows what crosses the ports: register writes and
    // pixel transfers, both as seen at the rising edge.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_we) apply_register(cfg_index, cfg_wdata);
            if (s_valid && s_ready) track_pixel(s_pixel_value);
        end
    end

    task automatic check_field(string name, logic [OUT_W-1:0] want, logic [OUT_W-1:0] got);
        if (got !== want) begin
            mismatches++;
            $display("%0t ns: %s expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    // Every rectangle transfer is matched against the oldest one owed.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_boxes.size() == 0) begin
                mismatches++;
                $display("%0t ns: rectangle expected none, actual %0d %0d %0d %0d", $time,
                         m_box_left, m_box_bottom, m_box_right, m_box_top);
            end else begin
                oldest_box = pending_boxes.pop_front();
                check_field("box_left", oldest_box.left, m_box_left);
                check_field("box_bottom", oldest_box.bottom, m_box_bottom);
                check_field("box_right", oldest_box.right, m_box_right);
                check_field("box_top", oldest_box.top, m_box_top);
            end
        end
    end

    // Receiver. A hold-off request takes priority and keeps ready low for a
    // long stretch; otherwise ready alternates between random runs of ready and
    // stall cycles, or stays high when stalls are switched off.
    always @(negedge aclk) begin
        if (hold_request) begin
            hold_request = 1'b0;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready = 1'b0;
        end else if (!rx_stalls_on) begin
            m_ready = 1'b1;
        end else begin
            if (rx_run == 0) begin
                rx_ready_phase = !rx_ready_phase;
                rx_run = rx_ready_phase ? $urandom_range(1, 12) : $urandom_range(1, 5);
            end
            rx_run--;
            m_ready = rx_ready_phase;
        end
    end

    // Offers one pixel and returns at the falling edge after its transfer.
    // Valid stays high into the next call, so back-to-back pixels need no gap.
    task automatic send_pixel(logic [PIX_W-1:0] pix);
        if (tx_gaps_on) begin
            if (burst_left == 0) begin
                s_valid = 1'b0;
                repeat ($urandom_range(1, 6)) @(negedge aclk);
                burst_left = $urandom_range(1, 16);
            end
            burst_left--;
        end
        s_valid = 1'b1;
        s_pixel_value = pix;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    // Registers are written only when nothing is in flight: every rectangle
    // owed has arrived and any trailing pixels have had time to settle.
    task automatic wait_idle();
        s_valid = 1'b0;
        while (pending_boxes.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_reg(logic [IDX_W-1:0] idx, int unsigned value);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_wdata = CFG_W'(value);
        @(negedge aclk);
        cfg_we    = 1'b0;
    endtask

    task automatic set_frame(int unsigned w, int unsigned h, int unsigned mask_en,
                             int unsigned mask_top, int unsigned mask_bottom);
        wait_idle();
        write_reg(CFG_IDX_FRAME_WIDTH, w);
        write_reg(CFG_IDX_FRAME_HEIGHT, h);
        write_reg(CFG_IDX_MASK_ENABLE, mask_en);
        write_reg(CFG_IDX_MASK_TOP, mask_top);
        write_reg(CFG_IDX_MASK_BOTTOM, mask_bottom);
    endtask

    // Starts at the reset sizes, then shrinks width and height while the
    // counters are already past the new limits, so rows and frames end early.
    task automatic test_midframe_config();
        send_pixel(8'h00);
        send_pixel(8'h40);
        send_pixel(8'h00);
        wait_idle();
        write_reg(CFG_IDX_FRAME_WIDTH, 2);
        write_reg(CFG_IDX_FRAME_HEIGHT, 2);
        send_pixel(8'h00);
        send_pixel(8'h02);
        send_pixel(8'h00);
        set_frame(4, 4, 0, 0, 0);
        for (int i = 0; i < 6; i++) send_pixel((i == 5) ? 8'h10 : 8'h00);
        wait_idle();
        write_reg(CFG_IDX_FRAME_WIDTH, 2);
        for (int i = 0; i < 5; i++) send_pixel((i == 4) ? 8'h08 : 8'h00);
    endtask

    // Three 3x3 frames: empty, a single center pixel, ink in all four corners.
    task automatic test_small_frames();
        set_frame(3, 3, 0, 0, 0);
        repeat (9) send_pixel(8'h00);
        for (int i = 0; i < 9; i++) send_pixel((i == 4) ? 8'h80 : 8'h00);
        for (int i = 0; i < 9; i++) begin
            case (i)
                0: send_pixel(8'hFF);
                2: send_pixel(8'h55);
                6: send_pixel(8'hAA);
                8: send_pixel(8'h01);
                default: send_pixel(8'h00);
            endcase
        end
    endtask

    // Fully inked 2x6 frames under several mask settings: plain bands,
    // overlapping bands, bands far beyond the frame, and an enable write
    // whose low bit is clear while the upper bits are set.
    task automatic test_mask_bands();
        set_frame(2, 6, 1, 2, 1);
        repeat (12) send_pixel(8'hFF);
        set_frame(2, 6, 1, 4, 4);
        repeat (12) send_pixel(8'hFF);
        set_frame(2, 6, 1, ALL_ONES_CFG, 0);
        repeat (12) send_pixel(8'hFF);
        set_frame(2, 6, 1, 0, ALL_ONES_CFG);
        repeat (12) send_pixel(8'hFF);
        set_frame(2, 6, ALL_ONES_CFG - 1, 3, 3);
        repeat (12) send_pixel(8'hFF);
    endtask

    // Writes to indexes that hold no register must leave the settings alone.
    task automatic test_spare_indexes();
        set_frame(2, 6, 1, 1, 1);
        for (int i = FIRST_SPARE_INDEX; i < (1 << IDX_W); i++) begin
            write_reg(IDX_W'(i), ALL_ONES_CFG);
        end
        for (int i = 0; i < 12; i++) send_pixel((i % 5 == 0) ? 8'h33 : 8'h00);
    endtask

    // Ink on row 5, then the height drops to 3: both vertical edges of the
    // rectangle would go below zero and must saturate.
    task automatic test_edge_below_zero();
        set_frame(2, 8, 0, 0, 0);
        for (int i = 0; i < 12; i++) send_pixel((i >= 10) ? 8'h7F : 8'h00);
        wait_idle();
        write_reg(CFG_IDX_FRAME_HEIGHT, 3);
        send_pixel(8'h00);
        send_pixel(8'h00);
    endtask

    // Out-of-range sizes. A zero width gives one-pixel rows and a zero height
    // one-row frames. A height of all ones acts as the largest dimension, which
    // shows in the lower mask band: only rows 6 and up fall in it. The height
    // then drops in mid-frame so that the frame ends at the next pixel.
    task automatic test_size_limits();
        set_frame(0, 3, 0, 0, 0);
        for (int i = 0; i < 3; i++) send_pixel((i == 1) ? 8'h21 : 8'h00);
        set_frame(5, 0, 0, 0, 0);
        for (int i = 0; i < 5; i++) send_pixel((i == 3) ? 8'h9C : 8'h00);
        set_frame(1, ALL_ONES_CFG, 1, 0, MAX_DIM - 6);
        repeat (8) send_pixel(8'hFF);
        wait_idle();
        write_reg(CFG_IDX_FRAME_HEIGHT, 8);
        send_pixel(8'hFF);
    endtask

    // One-pixel frames make every pixel the end of a frame. With the receiver
    // held off, a rectangle waits in the result register and the block refuses further pixels.
    task automatic test_backpressure();
        set_frame(1, 1, 0, 0, 0);
        tx_gaps_on = 1'b0;
        hold_request = 1'b1;
        repeat (60) send_pixel(PIX_W'($urandom_range(0, 255)));
        tx_gaps_on = 1'b1;
    endtask

    function automatic int unsigned pick_dimension();
        case ($urandom_range(0, 9))
            0:       return 0;
            1, 2:    return $urandom_range(7, 20);
            default: return $urandom_range(1, 6);
        endcase
    endfunction

    function automatic int unsigned pick_mask_rows(int unsigned h);
        case ($urandom_range(0, 15))
            0:       return ALL_ONES_CFG;
            1:       return MAX_DIM;
            default: return $urandom_range(0, h + 1);
        endcase
    endfunction

    // Mostly whole frames with random content under random settings. Some
    // phases stop partway into a frame, so the next settings take effect on
    // a frame already under way.
    task automatic test_random_frames();
        int unsigned pixels_sent;
        int unsigned w_reg;
        int unsigned h_reg;
        int unsigned area;
        int unsigned count;
        int unsigned density;
        logic [PIX_W-1:0] pix;
        pixels_sent = 0;
        while (pixels_sent < RANDOM_PIXELS) begin
            w_reg = pick_dimension();
            h_reg = pick_dimension();
            area  = limit_dimension(w_reg) * limit_dimension(h_reg);
            set_frame(w_reg, h_reg, $urandom_range(0, 1),
                      pick_mask_rows(limit_dimension(h_reg)),
                      pick_mask_rows(limit_dimension(h_reg)));
            tx_gaps_on   = ($urandom_range(0, 3) != 0);
            rx_stalls_on = ($urandom_range(0, 3) != 0);
            count = $urandom_range(1, 3) * area;
            if ($urandom_range(0, 4) == 0) count += $urandom_range(0, area - 1);
            if (count > RANDOM_PIXELS - pixels_sent) count = RANDOM_PIXELS - pixels_sent;
            density = $urandom_range(0, 3);
            repeat (count) begin
                case (density)
                    0: pix = '0;
                    1: pix = ($urandom_range(0, 9) == 0) ? PIX_W'($urandom_range(1, 255)) : '0;
                    2: pix = ($urandom_range(0, 1) == 0) ? PIX_W'($urandom_range(1, 255)) : '0;
                    default: pix = PIX_W'($urandom_range(0, 255));
                endcase
                send_pixel(pix);
            end
            pixels_sent += count;
        end
        tx_gaps_on   = 1'b1;
        rx_stalls_on = 1'b1;
    endtask

    initial begin
        clear_extent();
        mismatches   = 0;
        tx_gaps_on   = 1'b1;
        rx_stalls_on = 1'b1;
        burst_left   = 0;
        hold_request = 1'b0;
        hold_left    = 0;
        rx_ready_phase = 1'b0;
        rx_run       = 0;
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_midframe_config();
        test_small_frames();
        test_mask_bands();
        test_spare_indexes();
        test_edge_below_zero();
        test_size_limits();
        test_backpressure();
        test_random_frames();

        // Drain: every owed rectangle must arrive, then a quiet period shows
        // that nothing extra follows.
        wait_idle();
        if (mismatches == 0) begin
            $display("[page_ink_bounding_box_core] OK");
        end else begin
            $display("[page_ink_bounding_box_core] ERROR");
        end
        $finish;
    end

    // Watchdog well beyond the slowest legal run, including stalls and gaps.
    initial begin
        #TIMEOUT_NS;
        $display("timeout with %0d rectangles outstanding", pending_boxes.size());
        $display("[page_ink_bounding_box_core] ERROR");
        $finish;
    end

endmodule
